### hdl/lpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice point generator package
// Shared widths, register indexes, mode and status codes, constant tables
// and small helpers.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int MAX_DIM_DEF      = 1024;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int GUARD_BITS       = 8;

  localparam int CNT_W     = 11;  // row / column / point counts
  localparam int COL_W     = 14;  // column index and ring size
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 34;  // Q17.16 output coordinates
  localparam int CW        = 42;  // CORDIC datapath with guard bits
  localparam int TW        = 34;  // CORDIC angle accumulator
  localparam int ANG_W     = 32;  // angle in 2^-32 turns
  localparam int DEN_W     = COL_W;
  localparam int DIV_NW    = 32;
  localparam int PITCH_W   = 21;

  localparam int GAIN_Q30       = 652032875;
  localparam int GAIN_LO        = GAIN_Q30 % 65536;
  localparam int GAIN_HI        = GAIN_Q30 / 65536;
  localparam int SQRT3_Q16      = 113512;
  localparam int SQRT3_HALF_Q16 = 56756;
  localparam int RING_NUM       = 31421;
  localparam int RING_DEN       = 5000;
  localparam int NEAR_ORIGIN    = 6;

  // x / RING_DEN as (x * RING_RECIP) >> RING_SHIFT, exact for x below 2^27
  localparam int RING_SHIFT = 40;
  localparam int RING_RECIP =
    int'(((longint'(1) <<< RING_SHIFT) + longint'(RING_DEN) - 1) / longint'(RING_DEN));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_ROWS,
    CFG_COLS,
    CFG_SPACING,
    CFG_CENTER_X,
    CFG_CENTER_Z,
    CFG_SPIRAL,
    CFG_MIN_PTS
  } cfg_idx_e;

  localparam logic [2:0] MODE_RECT      = 3'd0;
  localparam logic [2:0] MODE_TRI       = 3'd1;
  localparam logic [2:0] MODE_TRI_CTR   = 3'd2;
  localparam logic [2:0] MODE_RING_FIX  = 3'd3;
  localparam logic [2:0] MODE_RING_EVEN = 3'd4;
  localparam logic [2:0] MODE_HEX       = 3'd5;

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_LAST  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;

  localparam logic [1:0] PH_MAIN   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEEK,
    S_NDIV,
    S_NWAIT,
    S_RCHK,
    S_AWAIT,
    S_GLO,
    S_GHI,
    S_X0,
    S_CWAIT,
    S_LPX,
    S_LPZ,
    S_LFIN,
    S_OUT
  } lpg_state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
  } lpg_polar_t;

  // atan(2^-i) in 2^-32 turns
  localparam logic [29:0] ATAN_TURNS [ATAN_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  function automatic logic [CNT_W-1:0] clamp_dim(logic [CNT_W-1:0] v, int maxd);
    return (int'(v) > maxd) ? CNT_W'(maxd) : v;
  endfunction

  // divide by 2^k, rounding toward zero
  function automatic logic signed [63:0] trunc_shr(logic signed [63:0] v, logic [1:0] k);
    return (v < 0) ? -((-v) >>> k) : (v >>> k);
  endfunction

  function automatic logic near_origin(logic signed [POS_W-1:0] x,
                                       logic signed [POS_W-1:0] z);
    return (x >= -POS_W'(NEAR_ORIGIN)) && (x <= POS_W'(NEAR_ORIGIN)) &&
           (z >= -POS_W'(NEAR_ORIGIN)) && (z <= POS_W'(NEAR_ORIGIN));
  endfunction

endpackage

### hdl/lpg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice point generator channels
// Request channel (restart flag) and point channel (coordinates, status).
// ----------------------------------------------------------------------------
interface lpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lpg_pnt_if;
  logic               valid;
  logic               ready;
  logic signed [33:0] pos_x;
  logic signed [33:0] pos_z;
  logic [1:0]         status;

  modport source (output valid, output pos_x, output pos_z, output status, input ready);
  modport sink (input valid, input pos_x, input pos_z, input status, output ready);
endinterface

### hdl/lattice_point_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice point generator
// Walks a centred planar lattice or ring pattern one point per request and
// returns the point plus the configured centre, flagged when it is the last.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      handshake
//  req_i     in   restart                      valid / ready
//  pnt_o     out  pos_x, pos_z, status         valid / ready
//  cfg       in   cfg_idx_i, cfg_data_i        cfg_we_i, no back-pressure
//
// An item runs two position searches (the point and a lookahead for the last
// flag). Lattice positions take three passes of the shared multiplier. Ring
// positions use the serial divider for the angle, four passes of the shared
// multiplier and the CORDIC; ring mode 4 adds two passes per position for
// the ring size (a product and a reciprocal multiply).
// Reset puts the registers at their defaults and the walk at its start.
// A result waits in the output register; no item is taken until it leaves.
// ----------------------------------------------------------------------------
module lattice_point_generator_unit #(
  parameter int MAX_DIM      = lpg_pkg::MAX_DIM_DEF,
  parameter int CORDIC_STEPS = lpg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpg_pkg::CFG_W-1:0]     cfg_data_i,
  lpg_req_if.sink                       req_i,
  lpg_pnt_if.source                     pnt_o
);
  import lpg_pkg::*;

  // configuration
  logic [2:0]        mode_q;
  logic [CNT_W-1:0]  rowc_q, colc_q, minp_q;
  logic [19:0]       spc_q;
  logic signed [31:0] cx_q, cz_q;
  logic [15:0]       spir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RECT;
      rowc_q <= CNT_W'(5);
      colc_q <= CNT_W'(5);
      spc_q  <= 20'd327680;
      cx_q   <= '0;
      cz_q   <= '0;
      spir_q <= '0;
      minp_q <= CNT_W'(6);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:     mode_q <= cfg_data_i[2:0];
        CFG_ROWS:     rowc_q <= cfg_data_i[CNT_W-1:0];
        CFG_COLS:     colc_q <= cfg_data_i[CNT_W-1:0];
        CFG_SPACING:  spc_q  <= cfg_data_i[19:0];
        CFG_CENTER_X: cx_q   <= $signed(cfg_data_i);
        CFG_CENTER_Z: cz_q   <= $signed(cfg_data_i);
        CFG_SPIRAL:   spir_q <= cfg_data_i[15:0];
        CFG_MIN_PTS:  minp_q <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  lpg_state_e state_q, state_d;

  logic [1:0]         cur_ph_q, cur_ph_d, w_ph_q, w_ph_d;
  logic [CNT_W-1:0]   cur_row_q, cur_row_d, w_row_q, w_row_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d, w_col_q, w_col_d;
  logic               done_q, done_d, look_q, look_d;
  logic [COL_W-1:0]   n_q, n_d;
  logic [ANG_W-1:0]   ang_q, ang_d;
  logic [31:0]        rad_q, rad_d;
  logic [63:0]        plo_q, plo_d, gsum;
  logic [PITCH_W-1:0] zp_q, zp_d, pitch, xp, zp;
  logic signed [POS_W-1:0] lx_q, lx_d, px_q, px_d, pz_q, pz_d;
  logic [1:0]         st_q, st_d;

  // shared multiplier
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p_q;

  always_ff @(posedge clk_i) begin
    if (mul_en) mul_p_q <= mul_a * mul_b;
  end

  // divider and CORDIC
  logic               div_start, div_done;
  logic [DEN_W-1:0]   div_rem0, div_den;
  logic [DIV_NW-1:0]  div_num, div_q;
  logic               cor_start, cor_done;
  logic signed [CW-1:0] cor_x0;
  lpg_polar_t         cor_res;

  lpg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem0_i  (div_rem0),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  lpg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x0_i    (cor_x0),
    .ang_i   (ang_q),
    .done_o  (cor_done),
    .res_o   (cor_res)
  );

  // walk geometry
  logic [CNT_W-1:0] rows_c, cols_c, minp_c, rr, cc;
  logic             rings, tri_mode, hex, ph1, odd;
  logic [1:0]       x_inc;
  logic signed [16:0] kxo, kz, kzm;
  logic signed [POS_W-1:0] lx_new, lz;
  logic [COL_W-1:0] ring_q;

  assign rows_c   = clamp_dim(rowc_q, MAX_DIM);
  assign cols_c   = clamp_dim(colc_q, MAX_DIM);
  assign minp_c   = clamp_dim(minp_q, MAX_DIM);
  assign rings    = (mode_q == MODE_RING_FIX) || (mode_q == MODE_RING_EVEN);
  assign tri_mode = (mode_q == MODE_TRI) || (mode_q == MODE_TRI_CTR);
  assign hex      = (mode_q == MODE_HEX);
  assign ph1      = (w_ph_q == PH_SECOND);
  assign odd      = (tri_mode || hex) && w_row_q[0];
  assign rr       = ph1 ? ((rows_c != '0) ? rows_c - 1'b1 : '0) : rows_c;
  assign cc       = ph1 ? ((cols_c != '0) ? cols_c - 1'b1 : '0) : cols_c;
  assign x_inc    = 2'(tri_mode && ph1) + 2'(odd);
  assign kxo    = $signed({2'b0, w_col_q, 1'b0}) - $signed({6'b0, cols_c}) + 17'sd1
                  + $signed({15'b0, x_inc});
  assign kz     = $signed({5'b0, w_row_q, 1'b0}) - $signed({6'b0, rows_c}) + 17'sd1
                  + $signed({16'b0, tri_mode && ph1});
  assign kzm    = hex ? (kz + (kz <<< 1)) : kz;
  assign pitch  = PITCH_W'((mul_p_q + 64'sd32768) >>> 16);
  assign xp     = hex ? pitch : {1'b0, spc_q};
  assign zp     = tri_mode ? pitch : {1'b0, spc_q};
  assign lx_new = POS_W'(trunc_shr(mul_p_q, 2'd1));
  assign lz     = POS_W'(trunc_shr(mul_p_q, hex ? 2'd2 : 2'd1));
  assign gsum   = plo_q + {mul_p_q[47:0], 16'b0};
  assign cor_x0 = $signed({2'b0, gsum[61:22]});
  // ring size from the reciprocal product, floored at min_points
  assign ring_q = (mul_p_q[RING_SHIFT +: COL_W] > {3'b0, minp_c}) ?
                  mul_p_q[RING_SHIFT +: COL_W] : {3'b0, minp_c};

  logic               hit, miss;
  logic signed [POS_W-1:0] hit_x, hit_z;

  always_comb begin
    state_d   = state_q;
    cur_ph_d  = cur_ph_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    w_ph_d    = w_ph_q;
    w_row_d   = w_row_q;
    w_col_d   = w_col_q;
    done_d    = done_q;
    look_d    = look_q;
    n_d       = n_q;
    ang_d     = ang_q;
    rad_d     = rad_q;
    plo_d     = plo_q;
    zp_d      = zp_q;
    lx_d      = lx_q;
    px_d      = px_q;
    pz_d      = pz_q;
    st_d      = st_q;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_rem0  = '0;
    div_num   = '0;
    div_den   = '0;
    cor_start = 1'b0;
    hit       = 1'b0;
    miss      = 1'b0;
    hit_x     = '0;
    hit_z     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.restart) begin
            cur_ph_d  = PH_MAIN;
            cur_row_d = '0;
            cur_col_d = '0;
            done_d    = 1'b0;
          end
          if (req_i.restart || !done_q) begin
            w_ph_d  = req_i.restart ? PH_MAIN : cur_ph_q;
            w_row_d = req_i.restart ? '0 : cur_row_q;
            w_col_d = req_i.restart ? '0 : cur_col_q;
            look_d  = 1'b0;
            state_d = S_SEEK;
          end
        end
      end
      S_SEEK: begin
        if (rings) begin
          if (w_ph_q == PH_MAIN) begin
            hit = 1'b1;
          end else if (w_ph_q != PH_SECOND) begin
            miss = 1'b1;
          end else if (w_row_q >= rows_c) begin
            w_ph_d = PH_DONE;
            miss   = 1'b1;
          end else if (mode_q == MODE_RING_FIX) begin
            n_d     = {3'b0, cols_c};
            state_d = S_RCHK;
          end else begin
            mul_en  = 1'b1;
            mul_a   = $signed({21'b0, w_row_q});
            mul_b   = 32'(RING_NUM);
            state_d = S_NDIV;
          end
        end else begin
          if (w_ph_q != PH_MAIN && w_ph_q != PH_SECOND) begin
            miss = 1'b1;
          end else if (ph1 && mode_q != MODE_TRI_CTR) begin
            w_ph_d = PH_DONE;
            miss   = 1'b1;
          end else if (w_row_q >= rr) begin
            if (!ph1 && mode_q == MODE_TRI_CTR) begin
              w_ph_d  = PH_SECOND;
              w_row_d = '0;
              w_col_d = '0;
            end else begin
              w_ph_d = PH_DONE;
              miss   = 1'b1;
            end
          end else if (w_col_q >= {3'b0, cc}) begin
            w_row_d = w_row_q + 1'b1;
            w_col_d = '0;
          end else begin
            mul_en  = 1'b1;
            mul_a   = $signed({12'b0, spc_q});
            mul_b   = hex ? 32'(SQRT3_Q16) : 32'(SQRT3_HALF_Q16);
            state_d = S_LPX;
          end
        end
      end
      S_NDIV: begin
        mul_en  = 1'b1;
        mul_a   = mul_p_q[31:0];
        mul_b   = 32'(RING_RECIP);
        state_d = S_NWAIT;
      end
      S_NWAIT: begin
        n_d     = ring_q;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (w_col_q >= n_q) begin
          w_row_d = w_row_q + 1'b1;
          w_col_d = '0;
          state_d = S_SEEK;
        end else begin
          div_start = 1'b1;
          div_rem0  = w_col_q;
          div_den   = n_q;
          mul_en    = 1'b1;
          mul_a     = $signed({16'b0, spir_q});
          mul_b     = $signed({21'b0, w_row_q});
          state_d   = S_AWAIT;
        end
      end
      S_AWAIT: begin
        if (div_done) begin
          ang_d   = div_q + {mul_p_q[15:0], 16'b0};
          mul_en  = 1'b1;
          mul_a   = $signed({21'b0, w_row_q});
          mul_b   = $signed({12'b0, spc_q});
          state_d = S_GLO;
        end
      end
      S_GLO: begin
        rad_d   = mul_p_q[31:0];
        mul_en  = 1'b1;
        mul_a   = mul_p_q[31:0];
        mul_b   = 32'(GAIN_LO);
        state_d = S_GHI;
      end
      S_GHI: begin
        plo_d   = mul_p_q;
        mul_en  = 1'b1;
        mul_a   = rad_q;
        mul_b   = 32'(GAIN_HI);
        state_d = S_X0;
      end
      S_X0: begin
        cor_start = 1'b1;
        state_d   = S_CWAIT;
      end
      S_CWAIT: begin
        if (cor_done) begin
          if (near_origin(cor_res.x, cor_res.z)) begin
            w_col_d = w_col_q + 1'b1;
            state_d = S_SEEK;
          end else begin
            hit   = 1'b1;
            hit_x = cor_res.x;
            hit_z = cor_res.z;
          end
        end
      end
      S_LPX: begin
        zp_d    = zp;
        mul_en  = 1'b1;
        mul_a   = 32'(kxo);
        mul_b   = $signed({11'b0, xp});
        state_d = S_LPZ;
      end
      S_LPZ: begin
        lx_d    = lx_new;
        mul_en  = 1'b1;
        mul_a   = 32'(kzm);
        mul_b   = $signed({11'b0, zp_q});
        state_d = S_LFIN;
      end
      S_LFIN: begin
        if (hex && near_origin(lx_q, lz)) begin
          w_col_d = w_col_q + 1'b1;
          state_d = S_SEEK;
        end else begin
          hit   = 1'b1;
          hit_x = lx_q;
          hit_z = lz;
        end
      end
      S_OUT: begin
        if (pnt_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (hit) begin
      if (!look_q) begin
        px_d = hit_x + POS_W'(cx_q);
        pz_d = hit_z + POS_W'(cz_q);
        // step past the emitted point, then look ahead from there
        if (rings && w_ph_q == PH_MAIN) begin
          cur_ph_d  = PH_SECOND;
          cur_row_d = '0;
          cur_col_d = '0;
        end else begin
          cur_ph_d  = w_ph_q;
          cur_row_d = w_row_q;
          cur_col_d = w_col_q + 1'b1;
        end
        w_ph_d  = cur_ph_d;
        w_row_d = cur_row_d;
        w_col_d = cur_col_d;
        look_d  = 1'b1;
        state_d = S_SEEK;
      end else begin
        st_d    = ST_POINT;
        state_d = S_OUT;
      end
    end else if (miss) begin
      if (!look_q) begin
        cur_ph_d  = w_ph_d;
        cur_row_d = w_row_d;
        cur_col_d = w_col_d;
        px_d      = '0;
        pz_d      = '0;
        st_d      = ST_END;
      end else begin
        st_d = ST_LAST;
      end
      done_d  = 1'b1;
      state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_ph_q  <= PH_MAIN;
      cur_row_q <= '0;
      cur_col_q <= '0;
      w_ph_q    <= PH_MAIN;
      w_row_q   <= '0;
      w_col_q   <= '0;
      done_q    <= 1'b0;
      look_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_ph_q  <= cur_ph_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      w_ph_q    <= w_ph_d;
      w_row_q   <= w_row_d;
      w_col_q   <= w_col_d;
      done_q    <= done_d;
      look_q    <= look_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    ang_q <= ang_d;
    rad_q <= rad_d;
    plo_q <= plo_d;
    zp_q  <= zp_d;
    lx_q  <= lx_d;
    px_q  <= px_d;
    pz_q  <= pz_d;
    st_q  <= st_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign pnt_o.valid  = (state_q == S_OUT);
  assign pnt_o.pos_x  = px_q;
  assign pnt_o.pos_z  = pz_q;
  assign pnt_o.status = st_q;

  // end marker carries no coordinates
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_o.valid && pnt_o.status == ST_END |-> pnt_o.pos_x == '0 && pnt_o.pos_z == '0)
    else $error("end marker with nonzero coordinates");

  // never taking a request while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && pnt_o.valid))
    else $error("request taken while result pending");

  // a last point or end marker closes the walk
  a_walk_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_o.valid && pnt_o.ready && pnt_o.status != ST_POINT |=> done_q)
    else $error("walk not closed after final item");

  // the CORDIC is only started on entry to its wait state in the ring sequence
  a_cordic_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_start |=> state_q == S_CWAIT && !div_done)
    else $error("CORDIC started outside ring point sequence");

endmodule

### hdl/lpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle. The remainder starts at
// rem0 (below den) and the bits of num are shifted in MSB first.
// ----------------------------------------------------------------------------
module lpg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lpg_pkg::DEN_W-1:0]  rem0_i,
  input  logic [lpg_pkg::DIV_NW-1:0] num_i,
  input  logic [lpg_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [lpg_pkg::DIV_NW-1:0] quot_o
);
  import lpg_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_NW);

  logic                busy_q, done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [DEN_W-1:0]    rem_q, den_q;
  logic [DIV_NW-1:0]   num_q;
  logic [DEN_W:0]      shift;
  logic                qbit;

  assign shift = {rem_q, num_q[DIV_NW-1]};
  assign qbit  = (shift >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem0_i;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= qbit ? DEN_W'(shift - {1'b0, den_q}) : DEN_W'(shift);
      num_q <= {num_q[DIV_NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### hdl/lpg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotates (x0, 0) by an angle in 2^-32 turns, one micro-rotation per cycle,
// then rounds off the guard bits. Angles past a quarter turn are folded.
// ----------------------------------------------------------------------------
module lpg_cordic #(
  parameter int CORDIC_STEPS = lpg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [lpg_pkg::CW-1:0]  x0_i,
  input  logic [lpg_pkg::ANG_W-1:0]      ang_i,
  output logic                           done_o,
  output lpg_pkg::lpg_polar_t            res_o
);
  import lpg_pkg::*;

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic signed [TW-1:0] QUARTER = TW'(64'sd1073741824);
  localparam logic signed [TW-1:0] HALF    = TW'(64'sd2147483648);

  logic                     busy_q, fin_q, flip_q;
  logic [STEP_W-1:0]        i_q;
  logic signed [CW-1:0]     x_q, y_q, dx, dy, xr, yr;
  logic signed [TW-1:0]     t_q, t0, tf, at;
  logic                     flip0;

  // fold into [-quarter, quarter]
  always_comb begin
    t0    = $signed({{(TW-ANG_W){ang_i[ANG_W-1]}}, ang_i});
    tf    = t0;
    flip0 = 1'b0;
    if (t0 > QUARTER) begin
      tf    = t0 - HALF;
      flip0 = 1'b1;
    end else if (t0 < -QUARTER) begin
      tf    = t0 + HALF;
      flip0 = 1'b1;
    end
  end

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign at = $signed({{(TW-30){1'b0}}, ATAN_TURNS[5'(i_q)]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      i_q    <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0_i;
      y_q    <= '0;
      t_q    <= tf;
      flip_q <= flip0;
    end else if (busy_q) begin
      if (t_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        t_q <= t_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        t_q <= t_q + at;
      end
    end
  end

  assign xr = (x_q + (CW'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign yr = (y_q + (CW'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;

  assign done_o  = fin_q;
  assign res_o.x = flip_q ? -POS_W'(xr) : POS_W'(xr);
  assign res_o.z = flip_q ? -POS_W'(yr) : POS_W'(yr);

endmodule
